>>> design/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, codes and sizing for the counting semaphore with wait queue.
// ----------------------------------------------------------------------------
package csf_pkg;

	// sizing of the wait queue and of the kept requester id
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;
	localparam int ID_KEEP     = (ID_WIDTH < 8) ? ID_WIDTH : 8;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W       = 16;

	// operation codes
	localparam logic [2:0] MODE_INIT     = 3'd0;
	localparam logic [2:0] MODE_TRY_DOWN = 3'd1;
	localparam logic [2:0] MODE_DOWN     = 3'd2;
	localparam logic [2:0] MODE_UP       = 3'd3;
	localparam logic [2:0] MODE_DESTROY  = 3'd4;

	// status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_QUEUED  = 3'd1;
	localparam logic [2:0] STAT_UNAVAIL = 3'd2;
	localparam logic [2:0] STAT_DEAD    = 3'd3;
	localparam logic [2:0] STAT_FULL    = 3'd4;
	localparam logic [2:0] STAT_BUSY    = 3'd5;

	// configuration register indexes
	localparam logic [0:0] REG_INITIAL_COUNT = 1'b0;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] requester_id;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             grant_valid;
		logic [7:0]       granted_id;
		logic [CNT_W-1:0] count_now;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture request, start queue head read
		logic exec;   // apply operation, load result register
	} cmd_t;

	typedef enum logic [0:0] {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

>>> design/csf_ram.sv
// ----------------------------------------------------------------------------
// csf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module csf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/csf_ctrl.sv
// ----------------------------------------------------------------------------
// csf_ctrl
// Sequencer: accept a request, execute it, hand the result to the output
// register and track that register's occupancy.
// ----------------------------------------------------------------------------
module csf_ctrl
	import csf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	// result register can take a new beat
	assign out_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> design/csf_dp.sv
// ----------------------------------------------------------------------------
// csf_dp
// Datapath: semaphore count, destroyed mark, wait queue pointers and storage,
// and the result register.
// ----------------------------------------------------------------------------
module csf_dp
	import csf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  req_t             req,
	input  logic [CNT_W-1:0] initial_count,
	output rsp_t             rsp
);

	req_t             op_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] count_q;
	logic             dead_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;

	logic [ID_KEEP-1:0] head_id;
	logic               avail;
	logic               do_enq;
	logic               do_deq;
	logic               do_init;
	logic               do_dec;
	logic               do_inc;
	logic               do_kill;
	rsp_t               rsp_d;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// waiter storage, head read issued when a request is captured
	csf_ram #(
		.WIDTH (ID_KEEP),
		.DEPTH (QUEUE_DEPTH)
	) u_waiters (
		.clk   (clk),
		.we    (cmd.exec && do_enq),
		.waddr (tail_q),
		.wdata (op_q.requester_id[ID_KEEP-1:0]),
		.re    (cmd.load),
		.raddr (head_q),
		.rdata (head_id)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req;
		end
	end

	assign avail = (count_q != '0) && (occ_q == '0);

	// operation decode
	always_comb begin
		do_enq  = 1'b0;
		do_deq  = 1'b0;
		do_init = 1'b0;
		do_dec  = 1'b0;
		do_inc  = 1'b0;
		do_kill = 1'b0;
		rsp_d             = '0;
		rsp_d.status      = STAT_UNAVAIL;
		if (op_q.mode == MODE_INIT) begin
			if (initial_count != '0) begin
				do_init      = 1'b1;
				rsp_d.status = STAT_OK;
			end
		end else if (dead_q) begin
			rsp_d.status = STAT_DEAD;
		end else begin
			case (op_q.mode)
				MODE_TRY_DOWN: begin
					if (avail) begin
						do_dec       = 1'b1;
						rsp_d.status = STAT_OK;
					end
				end
				MODE_DOWN: begin
					if (avail) begin
						do_dec       = 1'b1;
						rsp_d.status = STAT_OK;
					end else if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
						rsp_d.status = STAT_FULL;
					end else begin
						do_enq       = 1'b1;
						rsp_d.status = STAT_QUEUED;
					end
				end
				MODE_UP: begin
					if (occ_q != '0) begin
						do_deq            = 1'b1;
						rsp_d.grant_valid = 1'b1;
						rsp_d.granted_id  = 8'(head_id);
					end else if (count_q != '1) begin
						do_inc = 1'b1;
					end
					rsp_d.status = STAT_OK;
				end
				MODE_DESTROY: begin
					do_kill      = 1'b1;
					rsp_d.status = (count_q != initial_count) ? STAT_BUSY : STAT_OK;
				end
				default: rsp_d.status = STAT_UNAVAIL;
			endcase
		end
		// count after the operation
		if (do_init) begin
			rsp_d.count_now = initial_count;
		end else if (do_dec) begin
			rsp_d.count_now = count_q - CNT_W'(1);
		end else if (do_inc) begin
			rsp_d.count_now = count_q + CNT_W'(1);
		end else begin
			rsp_d.count_now = count_q;
		end
	end

	// semaphore and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			dead_q  <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else if (cmd.exec) begin
			count_q <= rsp_d.count_now;
			if (do_init) begin
				dead_q <= 1'b0;
				head_q <= '0;
				tail_q <= '0;
				occ_q  <= '0;
			end else begin
				if (do_kill) begin
					dead_q <= 1'b1;
				end
				if (do_enq) begin
					tail_q <= next_slot(tail_q);
					occ_q  <= occ_q + OCC_W'(1);
				end
				if (do_deq) begin
					head_q <= next_slot(head_q);
					occ_q  <= occ_q - OCC_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("wait queue occupancy beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == tail_q))
		else $error("empty queue with unequal pointers");

	a_kill_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_kill) |=> dead_q)
		else $error("destroy did not mark the semaphore");

	a_grant_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_deq) |=> (count_q == $past(count_q) && rsp_q.grant_valid))
		else $error("grant to waiter changed the count");
`endif

endmodule

>>> design/counting_semaphore_fifo.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo
// Counting semaphore with a FIFO of waiting requester ids and an APB
// register for the initial count.
// ----------------------------------------------------------------------------
//  channel  signals                          beat
//  req      req_valid / req_ready / req      mode, requester_id
//  rsp      rsp_valid / rsp_ready / rsp      status, grant_valid, granted_id,
//                                            count_now
//  cfg      psel penable pwrite paddr pwdata initial_count at byte address 0
//
//  Each operation is a capture plus queue head read, then an execute.
//  This split comes from the registered read port of the waiter RAM.
//  A new request is taken while the previous result waits in the output
//  register; execution of that request holds until the register is free.
//  Reset gives count 1, empty queue, not destroyed; no clearing pass.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo
	import csf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t             cmd;
	logic [CNT_W-1:0] initial_count_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_INITIAL_COUNT);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_count_q <= CNT_W'(1);
		end else if (psel && penable && pwrite && reg_sel) begin
			initial_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// read back
	assign prdata = reg_sel ? 32'(initial_count_q) : 32'd0;

	csf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	csf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req           (req),
		.initial_count (initial_count_q),
		.rsp           (rsp)
	);

endmodule
